### hw/rtl/crc_framed_packet_receiver_top_macros.svh
// assertion macros for the framed packet receiver
// used by crc_framed_packet_receiver_top; needs i_clk and i_rst_n in scope
`ifndef CRC_FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH
`define CRC_FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CFPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CFPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cfpr_pkg.sv
// shared constants and interface structs of the framed packet receiver
// no dependencies; used by every module under hw/rtl
package cfpr_pkg;

    // frame markers
    localparam logic [7:0] SYNC0   = 8'hA5;
    localparam logic [7:0] SYNC1   = 8'h5A;
    localparam logic [7:0] TRAILER = 8'hFF;

    // crc-16/modbus, reflected
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // payload buffer
    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // command that carries data words
    localparam logic [7:0] CMD_DATA = 8'h00;

    // request to the bit-serial crc unit
    typedef struct packed {
        logic       start;
        logic       seed;
        logic [7:0] data;
    } t_crc_ctl;

    // payload buffer write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

    // start of result emission for one good frame
    typedef struct packed {
        logic       start;
        logic [7:0] cmd;
        logic [7:0] len;
    } t_emit_req;

endpackage

### hw/rtl/cfpr_crc_serial.sv
// bit-serial crc-16/modbus unit, one polynomial step per cycle
// depends on cfpr_pkg
module cfpr_crc_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfpr_pkg::t_crc_ctl i_ctl,
    output logic [15:0]        o_crc,
    output logic               o_busy
);

    logic [15:0] r_crc;
    logic [2:0]  r_step;
    logic        r_busy;
    logic [15:0] w_seed;

    // either restart from the init value or continue the running crc
    assign w_seed = i_ctl.seed ? cfpr_pkg::CRC_INIT : r_crc;

    // load the byte, then shift eight times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= cfpr_pkg::CRC_INIT;
            r_step <= '0;
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_crc  <= w_seed ^ {8'h00, i_ctl.data};
            r_step <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_crc  <= {1'b0, r_crc[15:1]} ^ (r_crc[0] ? cfpr_pkg::CRC_POLY : 16'h0000);
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = r_busy;

endmodule

### hw/rtl/cfpr_payload_emit.sv
// payload buffer and result emitter: stores payload bytes, then reads them back
// into little-endian words, one byte per cycle within a word; depends on cfpr_pkg
module cfpr_payload_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfpr_pkg::t_buf_wr   i_wr,
    input  cfpr_pkg::t_emit_req i_req,
    output logic                o_busy,
    output logic                o_result_valid,
    input  logic                i_result_ready,
    output logic [7:0]          o_frame_command,
    output logic [31:0]         o_payload_word,
    output logic [1:0]          o_result_kind,
    output logic                o_last_of_frame
);

    typedef enum logic [3:0] {
        EM_IDLE  = 4'b0001,
        EM_FETCH = 4'b0010,
        EM_DRAIN = 4'b0100,
        EM_PUSH  = 4'b1000
    } t_emit_state;

    // payload memory
    logic [7:0] r_mem [cfpr_pkg::PAYLOAD_DEPTH];

    t_emit_state                r_state, n_state;
    logic [cfpr_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [1:0]                 r_byte_cnt, n_byte_cnt;
    logic [5:0]                 r_words_left, n_words_left;
    logic [7:0]                 r_cmd, n_cmd;
    logic [1:0]                 r_kind, n_kind;
    logic                       r_rd_pend;
    logic [7:0]                 r_rd_data;
    logic [31:0]                r_word;
    logic                       w_issue;
    logic                       w_load;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_cmd;
    logic [31:0] r_out_word;
    logic [1:0]  r_out_kind;
    logic        r_out_last;

    assign w_issue = (r_state == EM_FETCH);
    assign w_load  = (r_state == EM_PUSH) && (!r_out_valid || i_result_ready);

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // shift each read byte in at the top so byte 0 ends up lowest
    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_word <= {r_rd_data, r_word[31:8]};
        end
    end

    // emitter sequencing
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_byte_cnt   = r_byte_cnt;
        n_words_left = r_words_left;
        n_cmd        = r_cmd;
        n_kind       = r_kind;
        unique case (r_state)
            EM_IDLE: begin
                if (i_req.start) begin
                    n_cmd        = i_req.cmd;
                    n_addr       = '0;
                    n_byte_cnt   = '0;
                    n_words_left = i_req.len[7:2];
                    if (i_req.cmd != cfpr_pkg::CMD_DATA) begin
                        n_kind  = cfpr_pkg::KIND_UNKNOWN;
                        n_state = EM_PUSH;
                    end else if (i_req.len[7:2] == 6'd0) begin
                        n_kind  = cfpr_pkg::KIND_EMPTY;
                        n_state = EM_PUSH;
                    end else begin
                        n_kind  = cfpr_pkg::KIND_DATA;
                        n_state = EM_FETCH;
                    end
                end
            end
            EM_FETCH: begin
                n_addr     = r_addr + 1'b1;
                n_byte_cnt = r_byte_cnt + 2'd1;
                if (r_byte_cnt == 2'd3) begin
                    n_state = EM_DRAIN;
                end
            end
            EM_DRAIN: begin
                n_state = EM_PUSH;
            end
            EM_PUSH: begin
                if (w_load) begin
                    if (r_kind == cfpr_pkg::KIND_DATA && r_words_left != 6'd1) begin
                        n_words_left = r_words_left - 6'd1;
                        n_state      = EM_FETCH;
                    end else begin
                        n_state = EM_IDLE;
                    end
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= EM_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_issue;
        end
        r_addr       <= n_addr;
        r_byte_cnt   <= n_byte_cnt;
        r_words_left <= n_words_left;
        r_cmd        <= n_cmd;
        r_kind       <= n_kind;
    end

    // result register, freed by the downstream beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_cmd  <= r_cmd;
            r_out_kind <= r_kind;
            r_out_word <= (r_kind == cfpr_pkg::KIND_DATA) ? r_word : 32'h0;
            r_out_last <= (r_kind != cfpr_pkg::KIND_DATA) || (r_words_left == 6'd1);
        end
    end

    assign o_busy          = (r_state != EM_IDLE);
    assign o_result_valid  = r_out_valid;
    assign o_frame_command = r_out_cmd;
    assign o_payload_word  = r_out_word;
    assign o_result_kind   = r_out_kind;
    assign o_last_of_frame = r_out_last;

endmodule

### hw/rtl/crc_framed_packet_receiver_top.sv
// Framed packet receiver. Takes one received byte per beat and parses frames
// A5 5A, length, command, payload, CRC high, CRC low, FF, checking a
// CRC-16/Modbus over header through payload. A good frame with command 0
// gives one little-endian 32-bit word per four payload bytes (leftover bytes
// dropped, a single empty-frame result under four bytes); any other command
// gives one unknown-command result; the last result of a frame is flagged.
// Timing: after a byte that enters the CRC (header, length, command,
// payload), no byte is taken until the bit-serial CRC unit has finished its
// eight steps; the CRC and trailer bytes do not wait. After a good trailer no
// byte is taken until the last result of the frame has been loaded into the
// output register: each data word takes four reads of the payload memory, one
// drain and one push, an empty or unknown result a single push, plus any
// output stalls. The payload memory needs no clearing after reset.
// Depends on cfpr_pkg, cfpr_crc_serial, cfpr_payload_emit and the macro header.
`include "crc_framed_packet_receiver_top_macros.svh"

module crc_framed_packet_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_byte_valid,
    output logic        o_rx_byte_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_result_valid,
    input  logic        i_result_ready,
    output logic [7:0]  o_frame_command,
    output logic [31:0] o_payload_word,
    output logic [1:0]  o_result_kind,
    output logic        o_last_of_frame
);

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_SYNC   = 8'b0000_0010,
        PH_LEN    = 8'b0000_0100,
        PH_CMD    = 8'b0000_1000,
        PH_PAY    = 8'b0001_0000,
        PH_CRC_HI = 8'b0010_0000,
        PH_CRC_LO = 8'b0100_0000,
        PH_TRAIL  = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_crc_hi, n_crc_hi;

    cfpr_pkg::t_crc_ctl  w_crc_ctl;
    cfpr_pkg::t_buf_wr   w_wr;
    cfpr_pkg::t_emit_req w_req;
    logic [15:0]         w_crc;
    logic                w_crc_busy;
    logic                w_emit_busy;
    logic                w_rx_fire;
    logic                w_bad_end;
    logic [7:0]          w_count_inc;

    // a byte is taken only when the crc and the emitter are both free
    assign o_rx_byte_ready = !w_crc_busy && !w_emit_busy;
    assign w_rx_fire       = i_rx_byte_valid && o_rx_byte_ready;
    assign w_count_inc     = r_count + 8'd1;

    // frame parser
    always_comb begin
        n_phase        = r_phase;
        n_len          = r_len;
        n_cmd          = r_cmd;
        n_count        = r_count;
        n_crc_hi       = r_crc_hi;
        w_crc_ctl      = '0;
        w_crc_ctl.data = i_rx_byte;
        w_wr           = '0;
        w_wr.addr      = r_count;
        w_wr.data      = i_rx_byte;
        w_req          = '0;
        w_req.cmd      = r_cmd;
        w_req.len      = r_len;
        w_bad_end      = 1'b0;
        if (w_rx_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == cfpr_pkg::SYNC0) begin
                        n_phase         = PH_SYNC;
                        n_count         = '0;
                        w_crc_ctl.start = 1'b1;
                        w_crc_ctl.seed  = 1'b1;
                    end
                end
                PH_SYNC: begin
                    if (i_rx_byte == cfpr_pkg::SYNC1) begin
                        n_phase         = PH_LEN;
                        w_crc_ctl.start = 1'b1;
                    end else if (i_rx_byte == cfpr_pkg::SYNC0) begin
                        // repeated sync byte restarts the frame
                        n_count         = '0;
                        w_crc_ctl.start = 1'b1;
                        w_crc_ctl.seed  = 1'b1;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    n_len           = i_rx_byte;
                    n_phase         = PH_CMD;
                    w_crc_ctl.start = 1'b1;
                end
                PH_CMD: begin
                    n_cmd           = i_rx_byte;
                    n_count         = '0;
                    w_crc_ctl.start = 1'b1;
                    n_phase         = (r_len == 8'd0) ? PH_CRC_HI : PH_PAY;
                end
                PH_PAY: begin
                    w_wr.en         = 1'b1;
                    w_crc_ctl.start = 1'b1;
                    n_count         = w_count_inc;
                    if (w_count_inc == r_len) begin
                        n_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    n_crc_hi = i_rx_byte;
                    n_phase  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    if ({r_crc_hi, i_rx_byte} == w_crc) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        w_bad_end = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (i_rx_byte == cfpr_pkg::TRAILER) begin
                        n_phase     = PH_HUNT;
                        w_req.start = 1'b1;
                    end else begin
                        w_bad_end = 1'b1;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
            // bad crc or trailer: resync on a sync byte, else hunt
            if (w_bad_end) begin
                if (i_rx_byte == cfpr_pkg::SYNC0) begin
                    n_phase         = PH_SYNC;
                    n_count         = '0;
                    w_crc_ctl.start = 1'b1;
                    w_crc_ctl.seed  = 1'b1;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_len    <= '0;
            r_cmd    <= '0;
            r_count  <= '0;
            r_crc_hi <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_cmd    <= n_cmd;
            r_count  <= n_count;
            r_crc_hi <= n_crc_hi;
        end
    end

    // bit-serial crc
    cfpr_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .o_crc   (w_crc),
        .o_busy  (w_crc_busy)
    );

    // payload buffer and result emitter
    cfpr_payload_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (w_wr),
        .i_req           (w_req),
        .o_busy          (w_emit_busy),
        .o_result_valid  (o_result_valid),
        .i_result_ready  (i_result_ready),
        .o_frame_command (o_frame_command),
        .o_payload_word  (o_payload_word),
        .o_result_kind   (o_result_kind),
        .o_last_of_frame (o_last_of_frame)
    );

    // a good trailer beat always starts the emitter
    `CFPR_ASSERT_NEXT(a_trailer_starts_emit, w_rx_fire && r_phase == PH_TRAIL && i_rx_byte == cfpr_pkg::TRAILER, w_emit_busy, "good trailer did not start result emission")
    // payload writes never overlap emission reads
    `CFPR_ASSERT_NOW(a_no_write_while_emit, w_wr.en, !w_emit_busy, "payload write while emitting")
    // single-result frames are always flagged last
    `CFPR_ASSERT_NOW(a_single_result_last, o_result_valid && o_result_kind != cfpr_pkg::KIND_DATA, o_last_of_frame, "empty or unknown result not flagged last")
    // only defined result kinds leave the block
    `CFPR_ASSERT_NOW(a_kind_defined, o_result_valid, o_result_kind == cfpr_pkg::KIND_DATA || o_result_kind == cfpr_pkg::KIND_EMPTY || o_result_kind == cfpr_pkg::KIND_UNKNOWN, "undefined result kind")

endmodule
